[src/stt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table package
// Command, status and result codes, controller states and fixed widths that
// the timer table and its expiry memory share.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned CMD_W        = 2;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned EXPIRY_W     = 32;
  localparam int unsigned INDEX_W      = 4;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned CNT_W        = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ALREADY   = 2'd1,
    ST_NOT_ADDED = 2'd2
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

endpackage

[src/stt_expiry_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expiry memory
// One write port and one registered read port holding the absolute expiry
// time of every timer slot.
// ----------------------------------------------------------------------------
module stt_expiry_mem import stt_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned ADDR_W     = 4
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ADDR_W-1:0]    wr_addr_i,
  input  logic [TIME_BITS-1:0] wr_data_i,
  input  logic [ADDR_W-1:0]    rd_addr_i,
  output logic [TIME_BITS-1:0] rd_data_o
);

  logic [TIME_BITS-1:0] mem_q [NUM_TIMERS];
  logic [TIME_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/software_timer_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table
// Add and delete give their status in the cycle after they are accepted; a tick
// gives no status. A tick that reaches the deadline walks every slot of the
// expiry memory, one slot a cycle unless the output stalls.
// Reset clears all armed flags and the time counter, and sets the deadline
// to half range; the expiry memory holds no reset value.
// ----------------------------------------------------------------------------
module software_timer_table import stt_pkg::*; #(
  parameter int unsigned NUM_TIMERS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [SLOT_W-1:0]   slot_id_i,
  input  logic [EXPIRY_W-1:0] expiry_tick_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic [INDEX_W-1:0]  timer_index_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                last_o
);

  localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
  localparam logic [TIME_BITS-1:0] HALF_RANGE = {1'b0, {(TIME_BITS-1){1'b1}}};

  function automatic logic diff_pos(input logic [TIME_BITS-1:0] a,
                                    input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      chk_q, chk_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  pend_valid_q, pend_valid_d;
  logic [IDX_W-1:0]      pend_idx_q, pend_idx_d;
  logic [NUM_TIMERS-1:0] armed_q, armed_d;
  logic [TIME_BITS-1:0]  cur_q, cur_d;
  logic [TIME_BITS-1:0]  nd_q, nd_d;

  logic                  out_valid_q, out_valid_d;
  kind_e                 out_kind_q, out_kind_d;
  logic [INDEX_W-1:0]    out_idx_q, out_idx_d;
  status_e               out_status_q, out_status_d;
  logic                  out_last_q, out_last_d;

  logic                  wr_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [TIME_BITS-1:0]  rd_data;

  logic                  out_free;
  logic                  accept;
  logic                  slot_ok;
  logic [IDX_W-1:0]      slot_idx;
  logic [TIME_BITS-1:0]  exp_in;
  logic [TIME_BITS-1:0]  tick_time;
  logic                  scan_armed;
  logic                  scan_fire;
  logic                  scan_stall;

  stt_expiry_mem #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS),
    .ADDR_W     (IDX_W)
  ) u_expiry_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (slot_idx),
    .wr_data_i (exp_in),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_ok    = 32'(slot_id_i) < 32'(NUM_TIMERS);
  assign slot_idx   = IDX_W'(slot_id_i);
  assign exp_in     = TIME_BITS'(expiry_tick_i);
  assign tick_time  = cur_q + TIME_BITS'(1);

  assign scan_armed = armed_q[chk_q];
  assign scan_fire  = (state_q == S_SCAN) && scan_armed && !diff_pos(rd_data, cur_q)
                      && (cnt_q < CNT_W'(RESULT_LIMIT));
  assign scan_stall = scan_fire && pend_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      chk_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      armed_q      <= '0;
      cur_q        <= '0;
      nd_q         <= HALF_RANGE;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      chk_q        <= chk_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      armed_q      <= armed_d;
      cur_q        <= cur_d;
      nd_q         <= nd_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q   <= pend_idx_d;
    out_kind_q   <= out_kind_d;
    out_idx_q    <= out_idx_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  always_comb begin
    state_d      = state_q;
    chk_d        = chk_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    armed_d      = armed_q;
    cur_d        = cur_q;
    nd_d         = nd_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    rd_addr      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_ADD: begin
              out_valid_d  = 1'b1;
              out_kind_d   = KIND_STATUS;
              out_idx_d    = slot_id_i;
              out_last_d   = 1'b1;
              out_status_d = ST_NOT_ADDED;
              if (slot_ok) begin
                out_status_d      = armed_q[slot_idx] ? ST_ALREADY : ST_OK;
                armed_d[slot_idx] = 1'b1;
                wr_en             = 1'b1;
                if (diff_pos(nd_q, exp_in)) begin
                  nd_d = exp_in;
                end
              end
            end
            CMD_DEL: begin
              out_valid_d  = 1'b1;
              out_kind_d   = KIND_STATUS;
              out_idx_d    = slot_id_i;
              out_last_d   = 1'b1;
              out_status_d = ST_NOT_ADDED;
              if (slot_ok) begin
                out_status_d      = armed_q[slot_idx] ? ST_OK : ST_NOT_ADDED;
                armed_d[slot_idx] = 1'b0;
              end
            end
            CMD_TICK: begin
              cur_d = tick_time;
              if (!diff_pos(nd_q, tick_time)) begin
                state_d = S_SCAN;
                chk_d   = '0;
                cnt_d   = '0;
                nd_d    = tick_time + HALF_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        rd_addr = scan_stall ? chk_q : chk_q + IDX_W'(1);
        if (!scan_stall) begin
          if (scan_fire) begin
            armed_d[chk_q] = 1'b0;
            cnt_d          = cnt_q + CNT_W'(1);
            pend_valid_d   = 1'b1;
            pend_idx_d     = chk_q;
            if (pend_valid_q) begin
              out_valid_d  = 1'b1;
              out_kind_d   = KIND_EXPIRY;
              out_idx_d    = INDEX_W'(pend_idx_q);
              out_status_d = ST_OK;
              out_last_d   = 1'b0;
            end
          end else if (scan_armed && diff_pos(nd_q, rd_data)) begin
            nd_d = rd_data;
          end
          if (chk_q == LAST_IDX) begin
            state_d = S_FLUSH;
          end else begin
            chk_d = chk_q + IDX_W'(1);
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = KIND_EXPIRY;
          out_idx_d    = INDEX_W'(pend_idx_q);
          out_status_d = ST_OK;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign timer_index_o = out_idx_q;
  assign status_o      = out_status_q;
  assign last_o        = out_last_q;

`ifndef SYNTHESIS
  a_pend_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("pending expiry held while idle");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_q == KIND_STATUS) |-> out_last_q)
    else $error("status result not marked last");

  a_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_fire && !scan_stall) |=> !armed_q[$past(chk_q)])
    else $error("fired slot still armed");

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(RESULT_LIMIT))
    else $error("expiry count beyond result limit");
`endif

endmodule
